// ===== hw/rtl/apr_pkg.sv =====
`timescale 1ns / 1ps

package apr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int GAIN_W      = 31;
  localparam int COEF_W      = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_CELLS   = 3;
  localparam int NUM_STAGES  = 8;
  localparam int LANE_STAGES = NUM_STAGES - 1;

  // floor(k*v / 2^F) and floor(v*w / 2^F)
  localparam int KV_W   = 2 * DATA_W - FRAC_BITS;
  // 1-v, v-a, pairwise differences
  localparam int DIFF_W = DATA_W + 1;
  // v0+v1-2*v2
  localparam int S2_W   = DATA_W + 3;
  // clamped intermediate range [-2^62, 2^62-1]
  localparam int WIDE_W = 63;
  localparam int PROD_W = WIDE_W + DIFF_W;
  localparam int COUP_W = COEF_W + 1 + DIFF_W - FRAC_BITS;
  localparam int EPS_W  = FRAC_BITS - 3;
  localparam int SUM_W  = WIDE_W + 2;

  localparam longint FX_ONE = longint'(1) << FRAC_BITS;

  localparam logic signed [DATA_W-1:0] EPS_THRESH = DATA_W'((FX_ONE + 10) / 20);
  localparam logic [EPS_W-1:0]         EPS_LOW    = EPS_W'((FX_ONE + 5) / 10);
  localparam logic signed [DIFF_W-1:0] FX_ONE_D   = DIFF_W'(FX_ONE);

  localparam logic [GAIN_W-1:0] GAIN_RST     = GAIN_W'(8 * FX_ONE);
  localparam logic [COEF_W-1:0] THRESH_RST   = COEF_W'((FX_ONE + 10) / 20);
  localparam logic [DATA_W-1:0] OFFSET0_RST  = DATA_W'(-(FX_ONE / 2));
  localparam logic [DATA_W-1:0] OFFSET1_RST  = DATA_W'(-((7 * FX_ONE + 5) / 10));
  localparam logic [DATA_W-1:0] OFFSET2_RST  = '0;
  localparam logic [COEF_W-1:0] PAIR_RST     = COEF_W'((FX_ONE + 100) / 200);
  localparam logic [COEF_W-1:0] TO_THIRD_RST = COEF_W'((FX_ONE + 10) / 20);
  localparam logic [COEF_W-1:0] FROM_3RD_RST = COEF_W'((FX_ONE + 50) / 100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_K,
    CFG_THRESHOLD_A,
    CFG_OFFSET_CELL0,
    CFG_OFFSET_CELL1,
    CFG_OFFSET_CELL2,
    CFG_COUPLE_PAIR,
    CFG_COUPLE_TO_THIRD,
    CFG_COUPLE_FROM_THIRD
  } cfg_idx_e;

  typedef struct packed {
    logic signed [WIDE_W-1:0] cubic;  // clamped k*v*(1-v)*(v-a)
    logic signed [KV_W-1:0]   vw;     // v*w
    logic signed [DATA_W-1:0] rec;    // saturated recovery derivative
  } lane_res_t;

  // saturate to the 32-bit output range
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] x);
    logic all_one;
    logic all_zero;
    all_one  = &x[SUM_W-1:DATA_W-1];
    all_zero = ~|x[SUM_W-1:DATA_W-1];
    if (all_one || all_zero) begin
      return x[DATA_W-1:0];
    end else if (x[SUM_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== hw/rtl/apr_wmul.sv =====
`timescale 1ns / 1ps

// 63x33 signed multiply, floor by 2^F, clamp to the wide range.
// Three register stages: partial products, sum, shift/clamp.
module apr_wmul (
  input  logic                              clk_i,
  input  logic [2:0]                        load_i,
  input  logic signed [apr_pkg::WIDE_W-1:0] a_i,
  input  logic signed [apr_pkg::DIFF_W-1:0] b_i,
  output logic signed [apr_pkg::WIDE_W-1:0] p_o
);
  import apr_pkg::*;

  localparam int LO_W = WIDE_W - DATA_W;
  localparam int PP_W = DATA_W + DIFF_W;
  localparam int Q_W  = PROD_W - FRAC_BITS;

  logic signed [PP_W-1:0]   pp_lo_q, pp_hi_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [Q_W-1:0]    quo;
  logic                     ovf;
  logic signed [WIDE_W-1:0] p_d, p_q;

  always_comb begin
    prod_d = ({{(PROD_W-PP_W){pp_hi_q[PP_W-1]}}, pp_hi_q} << LO_W)
           + {{(PROD_W-PP_W){pp_lo_q[PP_W-1]}}, pp_lo_q};
    quo = prod_q[PROD_W-1:FRAC_BITS];
    ovf = !((&quo[Q_W-1:WIDE_W-1]) || (~|quo[Q_W-1:WIDE_W-1]));
    if (!ovf) begin
      p_d = quo[WIDE_W-1:0];
    end else if (quo[Q_W-1]) begin
      p_d = {1'b1, {(WIDE_W-1){1'b0}}};
    end else begin
      p_d = {1'b0, {(WIDE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      pp_lo_q <= $signed({1'b0, a_i[LO_W-1:0]}) * b_i;
      pp_hi_q <= $signed(a_i[WIDE_W-1:LO_W]) * b_i;
    end
    if (load_i[1]) begin
      prod_q <= prod_d;
    end
    if (load_i[2]) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/apr_lane.sv =====
`timescale 1ns / 1ps

// One cell: cubic term, v*w and recovery derivative. Results at stage 6.
module apr_lane (
  input  logic                                   clk_i,
  input  logic [apr_pkg::LANE_STAGES-1:0]        load_i,
  input  logic signed [apr_pkg::DATA_W-1:0]      v_i,
  input  logic signed [apr_pkg::DATA_W-1:0]      w_i,
  input  logic [apr_pkg::GAIN_W-1:0]             gain_k_i,
  input  logic [apr_pkg::COEF_W-1:0]             threshold_a_i,
  input  logic signed [apr_pkg::DATA_W-1:0]      offset_i,
  output apr_pkg::lane_res_t                     res_o
);
  import apr_pkg::*;

  localparam int RP_W = KV_W + EPS_W + 1;
  localparam int RS_W = RP_W - FRAC_BITS;

  logic signed [2*DATA_W-1:0] kv_full, vw_full;
  logic signed [RP_W-1:0]     rp;
  logic signed [KV_W-1:0]     r_d, rs_d;

  logic signed [KV_W-1:0]   kv0_q;
  logic signed [DIFF_W-1:0] om0_q;
  logic signed [DATA_W-1:0] w0_q;
  logic                     hi_q [2];
  logic signed [DIFF_W-1:0] va_q [4];
  logic signed [KV_W-1:0]   vw_q [LANE_STAGES];
  logic signed [KV_W-1:0]   r1_q, rs2_q;
  logic signed [DATA_W-1:0] rec_q [3:6];
  logic signed [WIDE_W-1:0] p2, p3;

  always_comb begin
    kv_full = $signed({1'b0, gain_k_i}) * v_i;
    vw_full = v_i * w_i;
    // k*v - w + ksi, no clamp reachable
    r_d = kv0_q - {{(KV_W-DATA_W){w0_q[DATA_W-1]}}, w0_q}
        + {{(KV_W-DATA_W){offset_i[DATA_W-1]}}, offset_i};
    // eps = 0.1 above threshold
    rp = r1_q * $signed({1'b0, EPS_LOW});
    rs_d = hi_q[1] ? {{(KV_W-RS_W){rp[RP_W-1]}}, rp[RP_W-1:FRAC_BITS]} : r1_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      kv0_q    <= kv_full[2*DATA_W-1:FRAC_BITS];
      vw_q[0]  <= vw_full[2*DATA_W-1:FRAC_BITS];
      om0_q    <= FX_ONE_D - {v_i[DATA_W-1], v_i};
      va_q[0]  <= {v_i[DATA_W-1], v_i} - {{(DIFF_W-COEF_W){1'b0}}, threshold_a_i};
      hi_q[0]  <= (v_i >= EPS_THRESH);
      w0_q     <= w_i;
    end
    if (load_i[1]) begin
      r1_q    <= r_d;
      hi_q[1] <= hi_q[0];
    end
    if (load_i[2]) begin
      rs2_q <= rs_d;
    end
    if (load_i[3]) begin
      rec_q[3] <= sat_data({{(SUM_W-KV_W){rs2_q[KV_W-1]}}, rs2_q});
    end
    for (int s = 1; s < 4; s++) begin
      if (load_i[s]) va_q[s] <= va_q[s-1];
    end
    for (int s = 1; s < LANE_STAGES; s++) begin
      if (load_i[s]) vw_q[s] <= vw_q[s-1];
    end
    for (int s = 4; s < LANE_STAGES; s++) begin
      if (load_i[s]) rec_q[s] <= rec_q[s-1];
    end
  end

  // (k*v)*(1-v), stages 1..3
  apr_wmul u_mul_om (
    .clk_i  (clk_i),
    .load_i (load_i[3:1]),
    .a_i    ({{(WIDE_W-KV_W){kv0_q[KV_W-1]}}, kv0_q}),
    .b_i    (om0_q),
    .p_o    (p2)
  );

  // ...*(v-a), stages 4..6
  apr_wmul u_mul_va (
    .clk_i  (clk_i),
    .load_i (load_i[6:4]),
    .a_i    (p2),
    .b_i    (va_q[3]),
    .p_o    (p3)
  );

  assign res_o.cubic = p3;
  assign res_o.vw    = vw_q[LANE_STAGES-1];
  assign res_o.rec   = rec_q[6];

endmodule

// ===== hw/rtl/apr_couple.sv =====
`timescale 1ns / 1ps

// Diffusive coupling terms for the three cells. Results at stage 6.
module apr_couple (
  input  logic                              clk_i,
  input  logic [apr_pkg::LANE_STAGES-1:0]   load_i,
  input  logic signed [apr_pkg::DATA_W-1:0] v_i [apr_pkg::NUM_CELLS],
  input  logic [apr_pkg::COEF_W-1:0]        pair_i,
  input  logic [apr_pkg::COEF_W-1:0]        to_third_i,
  input  logic [apr_pkg::COEF_W-1:0]        from_third_i,
  output logic signed [apr_pkg::COUP_W-1:0] coup_o [apr_pkg::NUM_CELLS]
);
  import apr_pkg::*;

  localparam int CM_W  = COEF_W + 1 + DIFF_W;
  localparam int CM2_W = COEF_W + 1 + S2_W;

  logic signed [DIFF_W-1:0] ve [NUM_CELLS];
  logic signed [DIFF_W-1:0] d_q [4];
  logic signed [S2_W-1:0]   s2_q;
  logic signed [CM_W-1:0]   m [4];
  logic signed [CM2_W-1:0]  m2;
  logic signed [COUP_W-1:0] t_q [5];
  logic signed [COUP_W-1:0] c_q [2:6][NUM_CELLS];

  always_comb begin
    for (int i = 0; i < NUM_CELLS; i++) begin
      ve[i] = {v_i[i][DATA_W-1], v_i[i]};
    end
    m[0] = $signed({1'b0, pair_i})       * d_q[0];
    m[1] = $signed({1'b0, from_third_i}) * d_q[1];
    m[2] = $signed({1'b0, pair_i})       * d_q[2];
    m[3] = $signed({1'b0, from_third_i}) * d_q[3];
    m2   = $signed({1'b0, to_third_i})   * s2_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      d_q[0] <= ve[1] - ve[0];
      d_q[1] <= ve[2] - ve[0];
      d_q[2] <= ve[0] - ve[1];
      d_q[3] <= ve[2] - ve[1];
      s2_q   <= {{2{ve[0][DIFF_W-1]}}, ve[0]} + {{2{ve[1][DIFF_W-1]}}, ve[1]}
              - {ve[2][DIFF_W-1], ve[2], 1'b0};
    end
    if (load_i[1]) begin
      for (int j = 0; j < 4; j++) begin
        t_q[j] <= m[j][CM_W-1:FRAC_BITS];
      end
      t_q[4] <= m2[FRAC_BITS +: COUP_W];
    end
    if (load_i[2]) begin
      c_q[2][0] <= t_q[0] + t_q[1];
      c_q[2][1] <= t_q[2] + t_q[3];
      c_q[2][2] <= t_q[4];
    end
    for (int s = 3; s < LANE_STAGES; s++) begin
      if (load_i[s]) c_q[s] <= c_q[s-1];
    end
  end

  assign coup_o = c_q[6];

endmodule

// ===== hw/rtl/apr_merge.sv =====
`timescale 1ns / 1ps

// Combines lane results with coupling terms; output register.
module apr_merge (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  apr_pkg::lane_res_t                lane_i [apr_pkg::NUM_CELLS],
  input  logic signed [apr_pkg::COUP_W-1:0] coup_i [apr_pkg::NUM_CELLS],
  output logic signed [apr_pkg::DATA_W-1:0] dexc_o [apr_pkg::NUM_CELLS],
  output logic signed [apr_pkg::DATA_W-1:0] drec_o [apr_pkg::NUM_CELLS]
);
  import apr_pkg::*;

  logic signed [SUM_W-1:0]  sum [NUM_CELLS];
  logic signed [DATA_W-1:0] dexc_q [NUM_CELLS];
  logic signed [DATA_W-1:0] drec_q [NUM_CELLS];

  always_comb begin
    for (int i = 0; i < NUM_CELLS; i++) begin
      sum[i] = {{(SUM_W-WIDE_W){lane_i[i].cubic[WIDE_W-1]}}, lane_i[i].cubic}
             - {{(SUM_W-KV_W){lane_i[i].vw[KV_W-1]}}, lane_i[i].vw}
             + {{(SUM_W-COUP_W){coup_i[i][COUP_W-1]}}, coup_i[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        dexc_q[i] <= sat_data(sum[i]);
        drec_q[i] <= lane_i[i].rec;
      end
    end
  end

  assign dexc_o = dexc_q;
  assign drec_o = drec_q;

endmodule

// ===== hw/rtl/three_cell_aliev_panfilov_rhs.sv =====
// Throughput: one transaction per cycle unless the pipeline is full and out_ready_i is
//   low; the 8-stage pipeline (two split wide multipliers of 3 stages each per lane)
//   advances stage by stage, bubbles collapse.
// Reset (rst_ni low, async): pipeline valids cleared, configuration registers
//   return to their defaults (k=8, a=0.05, ksi=-0.5/-0.7/0, couplings 0.005/0.05/0.01).
`timescale 1ns / 1ps

module three_cell_aliev_panfilov_rhs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [apr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [apr_pkg::DATA_W-1:0]        cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [apr_pkg::DATA_W-1:0] excite0_i,
  input  logic signed [apr_pkg::DATA_W-1:0] recover0_i,
  input  logic signed [apr_pkg::DATA_W-1:0] excite1_i,
  input  logic signed [apr_pkg::DATA_W-1:0] recover1_i,
  input  logic signed [apr_pkg::DATA_W-1:0] excite2_i,
  input  logic signed [apr_pkg::DATA_W-1:0] recover2_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [apr_pkg::DATA_W-1:0] dexcite0_o,
  output logic signed [apr_pkg::DATA_W-1:0] drecover0_o,
  output logic signed [apr_pkg::DATA_W-1:0] dexcite1_o,
  output logic signed [apr_pkg::DATA_W-1:0] drecover1_o,
  output logic signed [apr_pkg::DATA_W-1:0] dexcite2_o,
  output logic signed [apr_pkg::DATA_W-1:0] drecover2_o
);
  import apr_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0]        gain_k_q;
  logic [COEF_W-1:0]        threshold_a_q;
  logic signed [DATA_W-1:0] offset_q [NUM_CELLS];
  logic [COEF_W-1:0]        couple_pair_q, couple_to_q, couple_from_q;

  // pipeline occupancy: one valid bit per stage, last stage is the output register
  logic [NUM_STAGES-1:0] vld_q, vld_d, load;
  logic                  in_acc, out_acc;

  logic signed [DATA_W-1:0] v_in [NUM_CELLS];
  logic signed [DATA_W-1:0] w_in [NUM_CELLS];
  lane_res_t                lane_res [NUM_CELLS];
  logic signed [COUP_W-1:0] coup [NUM_CELLS];
  logic signed [DATA_W-1:0] dexc [NUM_CELLS];
  logic signed [DATA_W-1:0] drec [NUM_CELLS];

  assign v_in[0] = excite0_i;
  assign v_in[1] = excite1_i;
  assign v_in[2] = excite2_i;
  assign w_in[0] = recover0_i;
  assign w_in[1] = recover1_i;
  assign w_in[2] = recover2_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_k_q      <= GAIN_RST;
      threshold_a_q <= THRESH_RST;
      offset_q[0]   <= OFFSET0_RST;
      offset_q[1]   <= OFFSET1_RST;
      offset_q[2]   <= OFFSET2_RST;
      couple_pair_q <= PAIR_RST;
      couple_to_q   <= TO_THIRD_RST;
      couple_from_q <= FROM_3RD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_K:            gain_k_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_THRESHOLD_A:       threshold_a_q <= cfg_data_i[COEF_W-1:0];
        CFG_OFFSET_CELL0:      offset_q[0]   <= cfg_data_i;
        CFG_OFFSET_CELL1:      offset_q[1]   <= cfg_data_i;
        CFG_OFFSET_CELL2:      offset_q[2]   <= cfg_data_i;
        CFG_COUPLE_PAIR:       couple_pair_q <= cfg_data_i[COEF_W-1:0];
        CFG_COUPLE_TO_THIRD:   couple_to_q   <= cfg_data_i[COEF_W-1:0];
        CFG_COUPLE_FROM_THIRD: couple_from_q <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage takes new contents when it is empty or its contents move on.
  // This lets the front keep accepting while a result waits at the output.
  always_comb begin
    load[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      load[s] = !vld_q[s] || load[s+1];
    end
    vld_d[0] = load[0] ? in_valid_i : vld_q[0];
    for (int s = 1; s < NUM_STAGES; s++) begin
      vld_d[s] = load[s] ? vld_q[s-1] : vld_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  // one lane per cell: local kinetics
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_lane
    apr_lane u_lane (
      .clk_i         (clk_i),
      .load_i        (load[LANE_STAGES-1:0]),
      .v_i           (v_in[i]),
      .w_i           (w_in[i]),
      .gain_k_i      (gain_k_q),
      .threshold_a_i (threshold_a_q),
      .offset_i      (offset_q[i]),
      .res_o         (lane_res[i])
    );
  end

  // coupling terms run beside the lanes with the same stage timing
  apr_couple u_couple (
    .clk_i        (clk_i),
    .load_i       (load[LANE_STAGES-1:0]),
    .v_i          (v_in),
    .pair_i       (couple_pair_q),
    .to_third_i   (couple_to_q),
    .from_third_i (couple_from_q),
    .coup_o       (coup)
  );

  // final add, saturation and output register
  apr_merge u_merge (
    .clk_i  (clk_i),
    .load_i (load[NUM_STAGES-1]),
    .lane_i (lane_res),
    .coup_i (coup),
    .dexc_o (dexc),
    .drec_o (drec)
  );

  assign dexcite0_o  = dexc[0];
  assign drecover0_o = drec[0];
  assign dexcite1_o  = dexc[1];
  assign drecover1_o = drec[1];
  assign dexcite2_o  = dexc[2];
  assign drecover2_o = drec[2];

  // an empty output register means every stage can advance
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NUM_STAGES-1] |-> in_ready_o)
    else $error("input not ready with empty output register");

  // full pipeline under output stall must refuse input
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted into a full stalled pipeline");

  // an accepted transaction lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> vld_q[0])
    else $error("accepted transaction lost at first stage");

  // occupancy tracks accepted minus delivered transactions
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(vld_q) ==
      $past($countones(vld_q)) + $past(in_acc) - $past(out_acc)))
    else $error("pipeline occupancy mismatch");

endmodule

// ===== bench/tb_three_cell_aliev_panfilov_rhs.sv =====
`timescale 1ns / 1ps

module tb_three_cell_aliev_panfilov_rhs;
  import apr_pkg::*;

  localparam int HALF_PERIOD      = 4;
  localparam int RESET_CYCLES     = 3;
  localparam int RAND_PER_SETTING = 205;
  localparam int CYCLE_LIMIT      = 200_000;
  localparam int SETTLE_CYCLES    = 16;   // drain time before the summary; the pipeline is 8 deep
  localparam int MAX_REPORTS      = 32;
  localparam int NUM_PROBES       = 18;
  localparam int NUM_SETTINGS     = 7;
  localparam int NUM_REGS         = 8;

  // Q16.16 constants, worked out here rather than taken from the RTL
  localparam longint UNIT     = longint'(1) << FRAC_BITS;
  localparam longint EPS_KNEE = (UNIT + 10) / 20;   // 0.05: fast/slow recovery switch
  localparam longint EPS_SLOW = (UNIT + 5) / 10;    // 0.1
  localparam longint WIDE_HI  = (longint'(1) << 62) - 1;
  localparam longint WIDE_LO  = -(longint'(1) << 62);
  localparam longint OUT_HI   = (longint'(1) << 31) - 1;
  localparam longint OUT_LO   = -(longint'(1) << 31);

  // power-up register values, in register index order
  localparam longint REG_DEFAULT [NUM_REGS] = '{
    8 * UNIT, (UNIT + 10) / 20, -(UNIT / 2), -((7 * UNIT + 5) / 10), 0,
    (UNIT + 100) / 200, (UNIT + 10) / 20, (UNIT + 50) / 100
  };

  // one state vector or one derivative vector:
  // [0] excite0 [1] recover0 [2] excite1 [3] recover1 [4] excite2 [5] recover2
  typedef logic [0:5][DATA_W-1:0] six_t;

  typedef struct packed {
    six_t stim;
    logic known;    // want holds a hand-typed answer
    six_t want;
  } probe_t;

  typedef enum int {SET_RESET, SET_HIGH, SET_LOW, SET_DEFAULT, SET_TYPICAL, SET_WILD} setting_e;
  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_e;

  localparam setting_e PLAN [NUM_SETTINGS] = '{
    SET_RESET, SET_HIGH, SET_LOW, SET_DEFAULT, SET_TYPICAL, SET_WILD, SET_TYPICAL
  };

  // Directed transactions, run under the power-up registers. Rows with known set
  // carry answers that follow by inspection; the rest go through the predictor.
  localparam probe_t PROBES [NUM_PROBES] = '{
    // everything at rest: only the recovery offsets show up
    '{stim: {6{32'h0}}, known: 1'b1,
      want: {32'h0, 32'hFFFF_8000, 32'h0, 32'hFFFF_4CCD, 32'h0, 32'h0}},
    // most negative excitation: cubic clamps high, recovery saturates low
    '{stim: {3{32'h8000_0000, 32'h0}}, known: 1'b1,
      want: {3{32'h7FFF_FFFF, 32'h8000_0000}}},
    '{stim: {3{32'h7FFF_FFFF, 32'h0}}, known: 1'b0, want: '0},
    '{stim: {3{32'h0, 32'h7FFF_FFFF}}, known: 1'b0, want: '0},
    '{stim: {3{32'h0, 32'h8000_0000}}, known: 1'b0, want: '0},
    // straddle the 0.05 knee of the recovery rate
    '{stim: {32'h0000_0CCC, 32'h0000_4000, 32'h0000_0CCD, 32'h0000_4000,
             32'h0000_0CCE, 32'h0000_4000}, known: 1'b0, want: '0},
    // v = 1.0 kills the (1-v) factor
    '{stim: {3{32'h0001_0000, 32'h0000_8000}}, known: 1'b0, want: '0},
    // v = a kills the (v-a) factor
    '{stim: {3{32'h0000_0CCD, 32'h0}}, known: 1'b0, want: '0},
    // one-LSB negatives exercise floor rounding of products
    '{stim: {32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0001_0000},
      known: 1'b0, want: '0},
    '{stim: {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0},
      known: 1'b0, want: '0},
    // largest negative and positive coupling sums into cell 2
    '{stim: {32'h8000_0000, 32'h1234_5678, 32'h8000_0000, 32'hEDCB_A988,
             32'h7FFF_FFFF, 32'h0}, known: 1'b0, want: '0},
    '{stim: {32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF},
      known: 1'b0, want: '0},
    '{stim: {6{32'hAAAA_AAAA}}, known: 1'b0, want: '0},
    '{stim: {6{32'h5555_5555}}, known: 1'b0, want: '0},
    '{stim: {6{32'hFFFF_FFFF}}, known: 1'b0, want: '0},
    // excited cells with realistic values
    '{stim: {32'h0000_CCCD, 32'h0000_8000, 32'h0001_999A, 32'h0000_8000,
             32'hFFFF_8000, 32'h0002_0000}, known: 1'b0, want: '0},
    '{stim: {32'h0000_FFFF, 32'h0000_8000, 32'h0001_0001, 32'hFFFF_8000,
             32'h0000_0CCD, 32'h0000_0001}, known: 1'b0, want: '0},
    // recovery variable exactly cancels the offset
    '{stim: {32'h0, 32'hFFFF_8000, 32'h0, 32'hFFFF_4CCD, 32'h0, 32'h0}, known: 1'b1,
      want: '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [DATA_W-1:0]        cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] excite0_i;
  logic signed [DATA_W-1:0] recover0_i;
  logic signed [DATA_W-1:0] excite1_i;
  logic signed [DATA_W-1:0] recover1_i;
  logic signed [DATA_W-1:0] excite2_i;
  logic signed [DATA_W-1:0] recover2_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] dexcite0_o;
  logic signed [DATA_W-1:0] drecover0_o;
  logic signed [DATA_W-1:0] dexcite1_o;
  logic signed [DATA_W-1:0] drecover1_o;
  logic signed [DATA_W-1:0] dexcite2_o;
  logic signed [DATA_W-1:0] drecover2_o;

  // shadow copy of the register file, kept in step with every write
  longint k_gain;
  longint a_thr;
  longint ksi [3];
  longint c_pair;
  longint c_to;
  longint c_from;

  six_t  rate_q [$];    // derivative vectors still owed by the block
  string lane_name [6] = '{"dexcite0", "drecover0", "dexcite1", "drecover1",
                           "dexcite2", "drecover2"};

  int burst_left;
  int n_sent;
  int n_checked;
  int n_errors;
  int n_sat;
  int cycle_cnt;

  always #HALF_PERIOD clk_i = ~clk_i;

  three_cell_aliev_panfilov_rhs dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .excite0_i   (excite0_i),
    .recover0_i  (recover0_i),
    .excite1_i   (excite1_i),
    .recover1_i  (recover1_i),
    .excite2_i   (excite2_i),
    .recover2_i  (recover2_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dexcite0_o  (dexcite0_o),
    .drecover0_o (drecover0_o),
    .dexcite1_o  (dexcite1_o),
    .drecover1_o (drecover1_o),
    .dexcite2_o  (dexcite2_o),
    .drecover2_o (drecover2_o)
  );

  // ---------------------------------------------------------------------------
  // Fixed-point helpers. Intermediates live in [-2^62, 2^62-1]; 128-bit math
  // holds any product of two such values exactly.
  // ---------------------------------------------------------------------------
  function automatic longint wide_clamp(input logic signed [127:0] x);
    if (x > WIDE_HI) return WIDE_HI;
    if (x < WIDE_LO) return WIDE_LO;
    return longint'(x[63:0]);
  endfunction

  function automatic longint fx_sum(input longint x, input longint y);
    logic signed [127:0] px;
    logic signed [127:0] py;
    px = x;
    py = y;
    return wide_clamp(px + py);
  endfunction

  // floor(x*y / 2^F): arithmetic shift rounds toward minus infinity
  function automatic longint fx_mul(input longint x, input longint y);
    logic signed [127:0] px;
    logic signed [127:0] py;
    px = x;
    py = y;
    return wide_clamp((px * py) >>> FRAC_BITS);
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input longint x);
    if (x > OUT_HI) return OUT_HI[DATA_W-1:0];
    if (x < OUT_LO) return OUT_LO[DATA_W-1:0];
    return x[DATA_W-1:0];
  endfunction

  // derivatives of the three coupled cells under the current registers
  function automatic six_t derive_rates(input six_t s);
    longint v [3];
    longint w [3];
    longint dv [3];
    longint t;
    six_t   o;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(s[2*i]));
      w[i] = longint'($signed(s[2*i+1]));
    end
    for (int i = 0; i < 3; i++) begin
      // cubic term in the order ((k*v)*(1-v))*(v-a), then minus v*w
      t = fx_mul(fx_mul(fx_mul(k_gain, v[i]), UNIT - v[i]), v[i] - a_thr);
      dv[i] = fx_sum(t, -fx_mul(v[i], w[i]));
      // recovery: fast below the knee, ten times slower above it
      t = fx_sum(fx_sum(fx_mul(k_gain, v[i]), -w[i]), ksi[i]);
      if (v[i] >= EPS_KNEE) t = fx_mul(t, EPS_SLOW);
      o[2*i+1] = sat32(t);
    end
    dv[0] = fx_sum(dv[0], fx_sum(fx_mul(c_pair, v[1] - v[0]), fx_mul(c_from, v[2] - v[0])));
    dv[1] = fx_sum(dv[1], fx_sum(fx_mul(c_pair, v[0] - v[1]), fx_mul(c_from, v[2] - v[1])));
    dv[2] = fx_sum(dv[2], fx_mul(c_to, v[0] + v[1] - 2 * v[2]));
    for (int i = 0; i < 3; i++) o[2*i] = sat32(dv[i]);
    return o;
  endfunction

  function automatic void shadow_write(input cfg_idx_e r, input logic [DATA_W-1:0] d);
    case (r)
      CFG_GAIN_K:            k_gain = longint'(d[GAIN_W-1:0]);
      CFG_THRESHOLD_A:       a_thr  = longint'(d[COEF_W-1:0]);
      CFG_OFFSET_CELL0:      ksi[0] = longint'($signed(d));
      CFG_OFFSET_CELL1:      ksi[1] = longint'($signed(d));
      CFG_OFFSET_CELL2:      ksi[2] = longint'($signed(d));
      CFG_COUPLE_PAIR:       c_pair = longint'(d[COEF_W-1:0]);
      CFG_COUPLE_TO_THIRD:   c_to   = longint'(d[COEF_W-1:0]);
      CFG_COUPLE_FROM_THIRD: c_from = longint'(d[COEF_W-1:0]);
      default: ;
    endcase
  endfunction

  // register value for one setting of the run
  function automatic logic [DATA_W-1:0] pick_reg(input setting_e s, input cfg_idx_e r);
    logic             is_offset;
    logic [DATA_W-1:0] val;
    is_offset = (r == CFG_OFFSET_CELL0) || (r == CFG_OFFSET_CELL1) ||
                (r == CFG_OFFSET_CELL2);
    case (s)
      SET_HIGH: begin
        val = (r == CFG_GAIN_K || is_offset) ? 32'h7FFF_FFFF : 32'(UNIT);
      end
      SET_LOW: begin
        val = is_offset ? 32'h8000_0000 : 32'h0;
      end
      SET_TYPICAL: begin
        if (r == CFG_GAIN_K) val = $urandom_range(0, 32'(20 * UNIT));
        else if (is_offset) val = 32'(longint'($urandom_range(0, 32'(4 * UNIT))) - 2 * UNIT);
        else val = $urandom_range(0, 32'(UNIT));
      end
      SET_WILD: begin
        if (r == CFG_GAIN_K) val = $urandom() & 32'h7FFF_FFFF;
        else if (is_offset) val = $urandom();
        else val = $urandom_range(0, 32'(UNIT));
      end
      default: begin
        val = 32'(REG_DEFAULT[r]);
      end
    endcase
    return val;
  endfunction

  // Random state vector. Half are cells in their working range, some sit near the
  // knees of the model (eps switch, v=a, v=1, 0, -1/2), the rest is full-range noise.
  function automatic six_t draw_state();
    six_t        s;
    int unsigned kind;
    longint      base;
    kind = $urandom_range(0, 9);
    for (int f = 0; f < 6; f++) begin
      if (kind >= 7) begin
        s[f] = $urandom();
        if ($urandom_range(0, 7) == 0) s[f] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else if (f % 2 == 1) begin
        s[f] = 32'(longint'($urandom_range(0, 32'(4 * UNIT))) - UNIT);
      end else if (kind >= 5) begin
        case ($urandom_range(0, 4))
          0:       base = EPS_KNEE;
          1:       base = a_thr;
          2:       base = UNIT;
          3:       base = 0;
          default: base = -UNIT / 2;
        endcase
        s[f] = 32'(base + longint'($urandom_range(0, 4)) - 2);
      end else begin
        s[f] = 32'(longint'($urandom_range(0, 32'(3 * UNIT))) - UNIT / 2);
      end
    end
    return s;
  endfunction

  // Offer one transaction; called at a falling edge, returns at a falling edge.
  // Between bursts the input valid may drop for a random gap.
  task automatic offer(input six_t stim, input logic known, input six_t want);
    int gap;
    {excite0_i, recover0_i, excite1_i, recover1_i, excite2_i, recover2_i} = stim;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rate_q.push_back(known ? want : derive_rates(stim));
    n_sent++;
    @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: directed probes under power-up registers, then one random block
  // per register setting. Registers change only with the pipeline drained.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_valid_i = 1'b0;
    {excite0_i, recover0_i, excite1_i, recover1_i, excite2_i, recover2_i} = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    burst_left = 1;
    n_sent     = 0;
    n_checked  = 0;
    n_errors   = 0;
    n_sat      = 0;
    for (int r = 0; r < NUM_REGS; r++) shadow_write(cfg_idx_e'(r), 32'(REG_DEFAULT[r]));

    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (PLAN[p] == SET_RESET) begin
        for (int i = 0; i < NUM_PROBES; i++) begin
          offer(PROBES[i].stim, PROBES[i].known, PROBES[i].want);
        end
      end else begin
        // sender holds off until every owed result is out, then reprograms
        if (in_valid_i) in_valid_i = 1'b0;
        while (rate_q.size() != 0) @(negedge clk_i);
        for (int r = 0; r < NUM_REGS; r++) begin
          cfg_we_i   = 1'b1;
          cfg_idx_i  = cfg_idx_e'(r);
          cfg_data_i = pick_reg(PLAN[p], cfg_idx_e'(r));
          shadow_write(cfg_idx_e'(r), cfg_data_i);
          @(negedge clk_i);
        end
        cfg_we_i = 1'b0;
      end
      for (int i = 0; i < RAND_PER_SETTING; i++) begin
        offer(draw_state(), 1'b0, '0);
      end
    end

    if (in_valid_i) in_valid_i = 1'b0;
    while (rate_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Covered %0d transactions under %0d register settings, extremes included.",
             n_sent, NUM_SETTINGS);
    $display("Compared %0d results, %0d saturated fields seen, %0d mismatches.",
             n_checked, n_sat, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: ready follows its own pattern, switching between wide open,
  // random stalls and a fixed one-in-four cadence.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int    hold;
    sink_e mode;
    hold = 0;
    mode = SINK_OPEN;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        mode = sink_e'($urandom_range(0, 2));
        hold = $urandom_range(8, 80);
      end
      hold--;
      case (mode)
        SINK_OPEN:   out_ready_i = 1'b1;
        SINK_RANDOM: out_ready_i = ($urandom_range(0, 9) < 6);
        default:     out_ready_i = (hold % 4 == 0);
      endcase
    end
  end

  // every accepted result transaction is checked against the oldest expectation
  always @(posedge clk_i) begin : rate_check
    six_t got;
    six_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {dexcite0_o, drecover0_o, dexcite1_o, drecover1_o, dexcite2_o, drecover2_o};
      if (rate_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("%0t: result with nothing expected, actual %h", $time, got);
        end
      end else begin
        want = rate_q.pop_front();
        n_checked++;
        for (int f = 0; f < 6; f++) begin
          if (got[f] !== want[f]) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("%0t: %s expected %0d actual %0d", $time, lane_name[f],
                       $signed(want[f]), $signed(got[f]));
            end
          end
          if (got[f] == 32'h7FFF_FFFF || got[f] == 32'h8000_0000) n_sat++;
        end
      end
    end
  end

  // hard stop if the block hangs
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d results still owed.", cycle_cnt, rate_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/apr_pkg.sv
hw/rtl/apr_wmul.sv
hw/rtl/apr_lane.sv
hw/rtl/apr_couple.sv
hw/rtl/apr_merge.sv
hw/rtl/three_cell_aliev_panfilov_rhs.sv
bench/tb_three_cell_aliev_panfilov_rhs.sv
